FILE: sv/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants for the box frustum test: the beat that walks
// the row of plane cells and the fixed-point widths of the plane test.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int NRM_W   = 16;
    localparam int CRN_W   = 32;
    localparam int OFS_W   = 32;
    localparam int IDX_W   = 3;
    localparam int PRD_W   = NRM_W + CRN_W;
    localparam int FRAC_SH = 14;
    localparam int ACC_W   = PRD_W + 3;

    localparam logic MODE_PLANE  = 1'b0;
    localparam logic MODE_CORNER = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic                    mode;
        logic [IDX_W-1:0]        plane_index;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic signed [OFS_W-1:0] plane_offset;
        logic signed [CRN_W-1:0] corner_x;
        logic signed [CRN_W-1:0] corner_y;
        logic signed [CRN_W-1:0] corner_z;
        logic                    last;
        logic                    all_in;
    } t_beat;

endpackage

FILE: sv/afr_cell.sv
// ----------------------------------------------------------------------------
// afr_cell
// One plane of the frustum. Holds its plane, tests every corner beat that
// passes against it in two stages and keeps its own inside bit; on the last
// corner of a box it folds that bit into the beat's running all-inside flag.
// ----------------------------------------------------------------------------
module afr_cell import afr_pkg::*; #(
    parameter logic [IDX_W-1:0] CELL_IDX = 3'd0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_beat i_beat,
    output t_beat o_beat
);

    logic signed [NRM_W-1:0] r_nx;
    logic signed [NRM_W-1:0] r_ny;
    logic signed [NRM_W-1:0] r_nz;
    logic signed [OFS_W-1:0] r_off;

    t_beat                   r_s1;
    logic signed [PRD_W-1:0] r_px;
    logic signed [PRD_W-1:0] r_py;
    logic signed [PRD_W-1:0] r_pz;
    logic signed [OFS_W+FRAC_SH-1:0] r_pd;

    t_beat                   r_s2;
    logic                    r_inside;

    logic signed [PRD_W-1:0] n_px;
    logic signed [PRD_W-1:0] n_py;
    logic signed [PRD_W-1:0] n_pz;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_hit;
    logic                    w_corner;
    logic                    n_inside;
    t_beat                   n_s2;

    // plane load
    always_ff @(posedge i_clk) begin
        if (i_adv && i_beat.valid && i_beat.mode == MODE_PLANE
                && i_beat.plane_index == CELL_IDX) begin
            r_nx  <= i_beat.normal_x;
            r_ny  <= i_beat.normal_y;
            r_nz  <= i_beat.normal_z;
            r_off <= i_beat.plane_offset;
        end
    end

    // stage 1: products
    assign n_px = r_nx * i_beat.corner_x;
    assign n_py = r_ny * i_beat.corner_y;
    assign n_pz = r_nz * i_beat.corner_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1 <= i_beat;
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
            r_pd <= {r_off, {FRAC_SH{1'b0}}};
        end
    end

    // stage 2: sum and sign test
    assign w_acc    = ACC_W'(r_px) + ACC_W'(r_py) + ACC_W'(r_pz) + ACC_W'(r_pd);
    assign w_hit    = !w_acc[ACC_W-1] && (w_acc != '0);
    assign w_corner = r_s1.valid && (r_s1.mode == MODE_CORNER);
    assign n_inside = r_inside | w_hit;

    always_comb begin
        n_s2 = r_s1;
        if (w_corner && r_s1.last) begin
            n_s2.all_in = r_s1.all_in & n_inside;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_inside   <= 1'b0;
        end else if (i_adv) begin
            r_s2 <= n_s2;
            if (w_corner) begin
                r_inside <= r_s1.last ? 1'b0 : n_inside;
            end
        end
    end

    assign o_beat = r_s2;

endmodule

FILE: sv/aabb_frustum_test.sv
// ----------------------------------------------------------------------------
// aabb_frustum_test
// Box frustum culling: plane loads and box corners walk in order through a
// row of plane cells; every CORNER_COUNT-th corner yields one result beat.
// ----------------------------------------------------------------------------
// path: the last corner of a box passes the two register stages of each
// plane cell and then the output register before o_out_valid rises
// throughput: one beat (plane load or corner) per cycle while the row is
// not stalled; the row stalls only when a result reaches its end while the
// output register is still full and not taken
// reset: synchronous active low, clears the corner counter, inside bits and
// beat valids; planes are undefined until loaded
// ----------------------------------------------------------------------------
module aabb_frustum_test import afr_pkg::*; #(
    parameter int PLANE_COUNT  = 6,
    parameter int CORNER_COUNT = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_mode,
    input  logic [IDX_W-1:0]        i_plane_index,
    input  logic signed [NRM_W-1:0] i_normal_x,
    input  logic signed [NRM_W-1:0] i_normal_y,
    input  logic signed [NRM_W-1:0] i_normal_z,
    input  logic signed [OFS_W-1:0] i_plane_offset,
    input  logic signed [CRN_W-1:0] i_corner_x,
    input  logic signed [CRN_W-1:0] i_corner_y,
    input  logic signed [CRN_W-1:0] i_corner_z,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_box_visible
);

    localparam logic [2:0] LAST_IDX = 3'(CORNER_COUNT - 1);

    t_beat      w_chain [PLANE_COUNT+1];
    t_beat      w_head;
    logic [2:0] r_count;
    logic       r_out_valid;
    logic       r_vis;
    logic       w_adv;
    logic       w_res;
    logic       w_take;
    logic       w_last;

    assign w_take = i_in_valid && w_adv;
    assign w_last = (r_count == LAST_IDX);

    always_comb begin
        w_head.valid        = w_take;
        w_head.mode         = i_mode;
        w_head.plane_index  = i_plane_index;
        w_head.normal_x     = i_normal_x;
        w_head.normal_y     = i_normal_y;
        w_head.normal_z     = i_normal_z;
        w_head.plane_offset = i_plane_offset;
        w_head.corner_x     = i_corner_x;
        w_head.corner_y     = i_corner_y;
        w_head.corner_z     = i_corner_z;
        w_head.last         = w_last;
        w_head.all_in       = 1'b1;
    end

    assign w_chain[0] = w_head;

    // corner counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else if (w_take && i_mode == MODE_CORNER) begin
            r_count <= w_last ? 3'd0 : r_count + 3'd1;
        end
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        afr_cell #(
            .CELL_IDX (IDX_W'(g))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    assign w_res = w_chain[PLANE_COUNT].valid && w_chain[PLANE_COUNT].last
                && (w_chain[PLANE_COUNT].mode == MODE_CORNER);
    assign w_adv = !(w_res && r_out_valid && !i_out_ready);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res) begin
            r_vis <= w_chain[PLANE_COUNT].all_in;
        end
    end

    assign o_in_ready    = w_adv;
    assign o_out_valid   = r_out_valid;
    assign o_box_visible = r_vis;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_IDX)
        else $error("corner counter past group size");

    a_count_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_mode == MODE_CORNER && w_last) |=> (r_count == 3'd0))
        else $error("corner counter did not wrap after last corner");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !w_res) |=> !o_out_valid)
        else $error("result beat repeated after being taken");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_res && o_out_valid))
        else $error("row stalled without a pending result");

endmodule
